FILE: hdl/gpg_pkg.sv
// Shared types, constants and tables of the gradient pixel generator.
package gpg_pkg;

    localparam int MAX_COLORS   = 16;
    localparam int PAL_AW       = $clog2(MAX_COLORS);
    localparam int COORD_BITS   = 12;
    localparam int CORDIC_STEPS = 16;

    // pipeline geometry of the back end
    localparam int DIV_STEPS   = 32;
    localparam int SQRT_STEPS  = 16;
    localparam int LANE_STAGES = DIV_STEPS + SQRT_STEPS;
    localparam int SPIRAL_BITS = 46;

    // 16 * 683565276: spiral term in 2^-32 turns per Q14.4 unit
    localparam logic [33:0] SPIRAL_K = 34'd10937044416;

    // configuration register indexes
    localparam logic [2:0] CFG_ORIGIN_X      = 3'd0;
    localparam logic [2:0] CFG_ORIGIN_Y      = 3'd1;
    localparam logic [2:0] CFG_DEST_X        = 3'd2;
    localparam logic [2:0] CFG_DEST_Y        = 3'd3;
    localparam logic [2:0] CFG_GRADIENT_TYPE = 3'd4;
    localparam logic [2:0] CFG_COLOR_COUNT   = 3'd5;
    localparam logic [2:0] CFG_DEEP_OUTPUT   = 3'd6;

    // gradient type codes
    localparam logic [2:0] GT_LINEAR   = 3'd0;
    localparam logic [2:0] GT_RADIAL   = 3'd1;
    localparam logic [2:0] GT_CIRCULAR = 3'd2;
    localparam logic [2:0] GT_SPIRAL   = 3'd3;
    localparam logic [2:0] GT_SQUARE   = 3'd4;

    typedef struct packed {
        logic signed [18:0] origin_x;
        logic signed [18:0] origin_y;
        logic signed [18:0] dest_x;
        logic signed [18:0] dest_y;
        logic [2:0]         gradient_type;
        logic [4:0]         color_count;
        logic               deep_output;
    } t_cfg;

    // classified input item
    typedef struct packed {
        logic                  is_load;
        logic                  wr_en;
        logic [COORD_BITS-1:0] px;
        logic [COORD_BITS-1:0] py;
        logic [3:0]            idx;
        logic [31:0]           color;
    } t_item;

    typedef struct packed {
        logic [63:0] value;
        logic [16:0] factor;
    } t_res;

    // atan(2^-k) in 2^-32 turns
    function automatic logic [31:0] atan_turn(input int k);
        logic [31:0] v;
        case (k)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

endpackage

FILE: hdl/gpg_ram.sv
// Generic single-write, single-read RAM with registered read.
module gpg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hdl/gpg_front.sv
// Front end: accepts items, classifies them and queues them for the back end.
module gpg_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic                 i_kind,
    input  logic [11:0]          i_pixel_x,
    input  logic [11:0]          i_pixel_y,
    input  logic [3:0]           i_entry_index,
    input  logic [31:0]          i_entry_color,
    input  logic                 i_take,
    output logic                 o_avail,
    output gpg_pkg::t_item       o_item
);
    gpg_pkg::t_item r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    gpg_pkg::t_item w_item;
    logic           w_acc, w_take;

    // classify: load slots beyond the palette are dropped
    always_comb begin
        w_item.is_load = i_kind;
        w_item.wr_en   = i_kind &
                         ({1'b0, i_entry_index} < 5'(gpg_pkg::MAX_COLORS));
        w_item.px      = i_pixel_x[gpg_pkg::COORD_BITS-1:0];
        w_item.py      = i_pixel_y[gpg_pkg::COORD_BITS-1:0];
        w_item.idx     = i_entry_index;
        w_item.color   = i_entry_color;
    end

    assign full    = (r_cnt == 2'd2);
    assign o_avail = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign w_acc   = push & ~full;
    assign w_take  = i_take & o_avail;

    // two-entry queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_acc) r_wp <= ~r_wp;
            if (w_take) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(w_acc) - 2'(w_take);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_q[r_wp] <= w_item;
        end
    end
endmodule

FILE: hdl/gpg_outq.sv
// Output queue: holds finished results until the consumer pops them.
module gpg_outq (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  gpg_pkg::t_res i_res,
    output logic          o_space,
    output logic          empty,
    input  logic          pop,
    output gpg_pkg::t_res o_res
);
    gpg_pkg::t_res r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          w_pop;

    assign empty   = (r_cnt == 2'd0);
    assign w_pop   = pop & ~empty;
    assign o_space = (r_cnt != 2'd2) | w_pop;
    assign o_res   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(i_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_res;
        end
    end
endmodule

FILE: hdl/gpg_back.sv
// Back end: projection, palette lookup, blend; one item/clock while i_space.
module gpg_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  gpg_pkg::t_cfg  i_cfg,
    input  logic           i_avail,
    input  gpg_pkg::t_item i_item,
    output logic           o_take,
    input  logic           i_space,
    output logic           o_res_valid,
    output gpg_pkg::t_res  o_res
);
    localparam int LANE = gpg_pkg::LANE_STAGES;
    localparam int AW   = gpg_pkg::PAL_AW;

    typedef struct packed {
        logic               is_load;
        logic               wr_en;
        logic [3:0]         idx;
        logic [31:0]        color;
        logic               den_zero;
        logic               num_pos;
        logic               ge;
        logic               ang_zero;
        logic               ang_neg;
        logic [40:0]        den;
        logic [41:0]        dr;
        logic [31:0]        dq;
        logic [33:0]        srem;
        logic [15:0]        sroot;
        logic signed [33:0] cx;
        logic signed [33:0] cy;
        logic [31:0]        cz;
        logic [18:0]        sr;
        logic [45:0]        sn;
    } t_lane;

    logic en;
    assign en     = i_space;
    assign o_take = en & i_avail;

    // configuration-derived constants (stable while items are in flight)
    logic signed [19:0] r_odx, r_ody;
    logic signed [39:0] r_sqx, r_sqy;
    logic [40:0]        r_den;
    logic [19:0]        r_cheb;
    logic [18:0]        r_mabs;
    logic               r_mneg, r_mzero;
    logic [19:0]        w_aodx, w_aody;
    logic signed [18:0] w_m;

    assign w_aodx = r_odx[19] ? 20'(-r_odx) : r_odx;
    assign w_aody = r_ody[19] ? 20'(-r_ody) : r_ody;
    assign w_m    = (i_cfg.origin_x > i_cfg.dest_x) ? i_cfg.origin_x : i_cfg.dest_x;

    always_ff @(posedge i_clk) begin
        r_odx   <= 20'(i_cfg.dest_x) - 20'(i_cfg.origin_x);
        r_ody   <= 20'(i_cfg.dest_y) - 20'(i_cfg.origin_y);
        r_sqx   <= r_odx * r_odx;
        r_sqy   <= r_ody * r_ody;
        r_den   <= 41'(r_sqx) + 41'(r_sqy);
        r_cheb  <= (w_aodx > w_aody) ? w_aodx : w_aody;
        r_mneg  <= w_m[18];
        r_mzero <= (w_m == 19'sd0);
        r_mabs  <= w_m[18] ? 19'(-20'(w_m)) : 19'(w_m);
    end

    // P0: offsets from origin
    logic               r_p0_v, r_p0_load, r_p0_wr;
    logic [3:0]         r_p0_idx;
    logic [31:0]        r_p0_color;
    logic [gpg_pkg::COORD_BITS-1:0] r_p0_pix;
    logic signed [19:0] r_p0_opx, r_p0_opy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p0_v <= 1'b0;
        end else if (en) begin
            r_p0_v <= i_avail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p0_load  <= i_item.is_load;
            r_p0_wr    <= i_item.wr_en;
            r_p0_idx   <= i_item.idx;
            r_p0_color <= i_item.color;
            r_p0_pix   <= i_item.px;
            r_p0_opx   <= $signed(20'({i_item.px, 4'b0000})) - 20'(i_cfg.origin_x);
            r_p0_opy   <= $signed(20'({i_item.py, 4'b0000})) - 20'(i_cfg.origin_y);
        end
    end

    // P1: products, Chebyshev numerator, spiral numerator, CORDIC entry
    logic               r_p1_v, r_p1_load, r_p1_wr;
    logic [3:0]         r_p1_idx;
    logic [31:0]        r_p1_color;
    logic signed [39:0] r_p1_m1, r_p1_m2;
    logic [19:0]        r_p1_cheb;
    logic [45:0]        r_p1_sn;
    logic signed [33:0] r_p1_cx, r_p1_cy;
    logic [31:0]        r_p1_cz;
    logic               r_p1_azero, r_p1_aneg;
    logic signed [19:0] w_b1, w_b2;
    logic [19:0]        w_aopx, w_aopy;
    logic signed [33:0] w_x0, w_y0;

    assign w_b1   = (i_cfg.gradient_type == gpg_pkg::GT_RADIAL) ? r_p0_opx : r_odx;
    assign w_b2   = (i_cfg.gradient_type == gpg_pkg::GT_RADIAL) ? r_p0_opy : r_ody;
    assign w_aopx = r_p0_opx[19] ? 20'(-r_p0_opx) : r_p0_opx;
    assign w_aopy = r_p0_opy[19] ? 20'(-r_p0_opy) : r_p0_opy;
    assign w_x0   = 34'(r_p0_opy) <<< 10;
    assign w_y0   = 34'(r_p0_opx) <<< 10;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
        end else if (en) begin
            r_p1_v <= r_p0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1_load  <= r_p0_load;
            r_p1_wr    <= r_p0_wr;
            r_p1_idx   <= r_p0_idx;
            r_p1_color <= r_p0_color;
            r_p1_m1    <= r_p0_opx * w_b1;
            r_p1_m2    <= r_p0_opy * w_b2;
            r_p1_cheb  <= (w_aopx > w_aopy) ? w_aopx : w_aopy;
            r_p1_sn    <= {{(46-gpg_pkg::COORD_BITS){1'b0}}, r_p0_pix} *
                          {12'b0, gpg_pkg::SPIRAL_K};
            r_p1_azero <= (r_p0_opx == 20'sd0) && (r_p0_opy == 20'sd0);
            r_p1_aneg  <= (r_p0_opx == 20'sd0) && r_p0_opy[19];
            // fold the left half plane over, starting at half a turn
            if (r_p0_opy[19]) begin
                r_p1_cx <= -w_x0;
                r_p1_cy <= -w_y0;
                r_p1_cz <= 32'h80000000;
            end else begin
                r_p1_cx <= w_x0;
                r_p1_cy <= w_y0;
                r_p1_cz <= 32'h0;
            end
        end
    end

    // P2: numerator/divisor select and lane entry
    t_lane              r_p2;
    logic               r_p2_v;
    logic signed [40:0] w_sum, w_num;
    logic [40:0]        w_dsel;
    logic               w_ge;

    always_comb begin
        w_sum = 41'(r_p1_m1) + 41'(r_p1_m2);
        case (i_cfg.gradient_type)
            gpg_pkg::GT_SQUARE: begin
                w_num  = $signed({21'b0, r_p1_cheb});
                w_dsel = {21'b0, r_cheb};
            end
            default: begin
                w_num  = w_sum;
                w_dsel = r_den;
            end
        endcase
        w_ge = !w_num[40] && (w_num[40:0] >= w_dsel);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p2_v <= 1'b0;
        end else if (en) begin
            r_p2_v <= r_p1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p2.is_load  <= r_p1_load;
            r_p2.wr_en    <= r_p1_wr;
            r_p2.idx      <= r_p1_idx;
            r_p2.color    <= r_p1_color;
            r_p2.den_zero <= (w_dsel == 41'd0);
            r_p2.num_pos  <= (w_num > 41'sd0);
            r_p2.ge       <= w_ge;
            r_p2.ang_zero <= r_p1_azero;
            r_p2.ang_neg  <= r_p1_aneg;
            r_p2.den      <= w_dsel;
            r_p2.dr       <= (w_ge || w_num[40]) ? 42'd0 : {1'b0, w_num[40:0]};
            r_p2.dq       <= 32'd0;
            r_p2.srem     <= 34'd0;
            r_p2.sroot    <= 16'd0;
            r_p2.cx       <= r_p1_cx;
            r_p2.cy       <= r_p1_cy;
            r_p2.cz       <= r_p1_cz;
            r_p2.sr       <= 19'd0;
            r_p2.sn       <= r_p1_sn;
        end
    end

    // lane: divider steps, then root steps; CORDIC and spiral divide alongside
    t_lane           r_lane [LANE];
    logic [LANE-1:0] r_lv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lv <= '0;
        end else if (en) begin
            r_lv <= {r_lv[LANE-2:0], r_p2_v};
        end
    end

    for (genvar k = 0; k < LANE; k++) begin : g_lane
        localparam int SI = (k >= gpg_pkg::DIV_STEPS) ? (LANE - 1 - k) : 0;
        localparam int CK = (k < gpg_pkg::CORDIC_STEPS) ? k : 0;
        t_lane cur, nxt;

        if (k == 0) begin : g_first
            assign cur = r_p2;
        end else begin : g_next
            assign cur = r_lane[k-1];
        end

        always_comb begin
            logic [41:0]        r2;
            logic [33:0]        v, trial;
            logic signed [33:0] sx, sy;
            logic [19:0]        rem;
            r2    = '0;
            v     = '0;
            trial = '0;
            sx    = '0;
            sy    = '0;
            rem   = '0;
            nxt   = cur;
            // one quotient bit of num/den
            if (k < gpg_pkg::DIV_STEPS) begin
                r2 = {cur.dr[40:0], 1'b0};
                if (r2 >= {1'b0, cur.den}) begin
                    nxt.dr = r2 - {1'b0, cur.den};
                    nxt.dq = {cur.dq[30:0], 1'b1};
                end else begin
                    nxt.dr = r2;
                    nxt.dq = {cur.dq[30:0], 1'b0};
                end
            end else begin
                // one root bit of the 32-bit quotient
                v     = (k == gpg_pkg::DIV_STEPS) ? {2'b00, cur.dq} : cur.srem;
                trial = (34'(cur.sroot) << (SI + 1)) + (34'd1 << (2 * SI));
                if (v >= trial) begin
                    nxt.srem  = v - trial;
                    nxt.sroot = cur.sroot | (16'd1 << SI);
                end else begin
                    nxt.srem  = v;
                end
            end
            // vectoring CORDIC rotation
            if (k < gpg_pkg::CORDIC_STEPS) begin
                sx = cur.cy >>> CK;
                sy = cur.cx >>> CK;
                if (cur.cy > 34'sd0) begin
                    nxt.cx = cur.cx + sx;
                    nxt.cy = cur.cy - sy;
                    nxt.cz = cur.cz + gpg_pkg::atan_turn(CK);
                end else begin
                    nxt.cx = cur.cx - sx;
                    nxt.cy = cur.cy + sy;
                    nxt.cz = cur.cz - gpg_pkg::atan_turn(CK);
                end
            end
            // spiral term: one quotient bit of pixel*K / |m|
            if (k < gpg_pkg::SPIRAL_BITS) begin
                rem = {cur.sr, cur.sn[45]};
                if (rem >= {1'b0, r_mabs}) begin
                    nxt.sr = 19'(rem - {1'b0, r_mabs});
                    nxt.sn = {cur.sn[44:0], 1'b1};
                end else begin
                    nxt.sr = rem[18:0];
                    nxt.sn = {cur.sn[44:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (en) begin
                r_lane[k] <= nxt;
            end
        end
    end

    // F0: blend factor per gradient type
    t_lane              w_lo;
    logic [32:0]        w_ang;
    logic signed [47:0] w_t, w_r;
    logic [16:0]        w_f;
    logic               r_f0_v, r_f0_load, r_f0_wr;
    logic [3:0]         r_f0_idx;
    logic [31:0]        r_f0_color;
    logic [16:0]        r_f0_f;

    assign w_lo = r_lane[LANE-1];

    always_comb begin
        if (w_lo.ang_zero) begin
            w_ang = 33'h080000000;
        end else if (w_lo.ang_neg) begin
            w_ang = 33'h100000000;
        end else begin
            w_ang = {1'b0, w_lo.cz + 32'h80000000};
        end
        w_r = r_mneg ? -$signed({2'b00, w_lo.sn}) : $signed({2'b00, w_lo.sn});
        w_t = $signed({15'b0, w_ang}) + w_r;
        case (i_cfg.gradient_type)
            gpg_pkg::GT_LINEAR: begin
                if (w_lo.den_zero || !w_lo.num_pos) w_f = 17'd0;
                else if (w_lo.ge) w_f = 17'h10000;
                else w_f = {1'b0, w_lo.dq[31:16]};
            end
            gpg_pkg::GT_RADIAL: begin
                if (w_lo.den_zero) w_f = 17'd0;
                else if (w_lo.ge) w_f = 17'h10000;
                else w_f = {1'b0, w_lo.sroot};
            end
            gpg_pkg::GT_CIRCULAR: w_f = w_ang[32:16];
            gpg_pkg::GT_SPIRAL: begin
                if (r_mzero || w_t[47]) w_f = 17'd0;
                else w_f = {1'b0, w_t[31:16]};
            end
            gpg_pkg::GT_SQUARE: begin
                if (w_lo.den_zero) w_f = 17'd0;
                else if (w_lo.ge) w_f = 17'h10000;
                else w_f = {1'b0, w_lo.dq[31:16]};
            end
            default: w_f = 17'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f0_v <= 1'b0;
        end else if (en) begin
            r_f0_v <= r_lv[LANE-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f0_load  <= w_lo.is_load;
            r_f0_wr    <= w_lo.wr_en;
            r_f0_idx   <= w_lo.idx;
            r_f0_color <= w_lo.color;
            r_f0_f     <= w_f;
        end
    end

    // F1: palette slot selection; loads write the palette here, in order
    logic [AW:0]    w_n, w_wm1, w_i;
    logic [AW+16:0] w_scl;
    logic [AW-1:0]  w_ra0, w_ra1;
    logic [15:0]    w_x;
    logic           w_circ;
    logic [31:0]    w_rd0, w_rd1;
    logic           r_f1_v, r_f1_load;
    logic [16:0]    r_f1_f;
    logic [15:0]    r_f1_x;

    always_comb begin
        if (i_cfg.color_count == 5'd0) begin
            w_n = (AW+1)'(1);
        end else if ({1'b0, i_cfg.color_count} > 6'(gpg_pkg::MAX_COLORS)) begin
            w_n = (AW+1)'(gpg_pkg::MAX_COLORS);
        end else begin
            w_n = (AW+1)'(i_cfg.color_count);
        end
        w_circ = (i_cfg.gradient_type == gpg_pkg::GT_CIRCULAR) ||
                 (i_cfg.gradient_type == gpg_pkg::GT_SPIRAL);
        w_wm1  = w_n - (AW+1)'(1) + (AW+1)'(w_circ);
        w_scl  = (AW+17)'(r_f0_f[15:0]) * (AW+17)'(w_wm1);
        w_i    = w_scl[AW+16:16];
        w_ra0  = '0;
        w_ra1  = '0;
        w_x    = 16'd0;
        if (w_n == (AW+1)'(1) || r_f0_f == 17'd0) begin
            w_ra0 = '0;
            w_ra1 = '0;
        end else if (r_f0_f[16]) begin
            w_ra0 = AW'(w_n - (AW+1)'(1));
            w_ra1 = AW'(w_n - (AW+1)'(1));
        end else begin
            w_x = w_scl[15:0];
            if (w_i >= w_n - (AW+1)'(1)) begin
                w_ra0 = AW'(w_n - (AW+1)'(1));
                w_ra1 = '0;
            end else begin
                w_ra0 = w_i[AW-1:0];
                w_ra1 = AW'(w_i + (AW+1)'(1));
            end
        end
    end

    gpg_ram #(.WIDTH(32), .DEPTH(gpg_pkg::MAX_COLORS)) u_pal0 (
        .i_clk   (i_clk),
        .i_we    (en & r_f0_v & r_f0_wr),
        .i_waddr (r_f0_idx[AW-1:0]),
        .i_wdata (r_f0_color),
        .i_re    (en),
        .i_raddr (w_ra0),
        .o_rdata (w_rd0)
    );

    gpg_ram #(.WIDTH(32), .DEPTH(gpg_pkg::MAX_COLORS)) u_pal1 (
        .i_clk   (i_clk),
        .i_we    (en & r_f0_v & r_f0_wr),
        .i_waddr (r_f0_idx[AW-1:0]),
        .i_wdata (r_f0_color),
        .i_re    (en),
        .i_raddr (w_ra1),
        .o_rdata (w_rd1)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_v <= 1'b0;
        end else if (en) begin
            r_f1_v <= r_f0_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f1_load <= r_f0_load;
            r_f1_f    <= r_f0_f;
            r_f1_x    <= w_x;
        end
    end

    // F2: per-channel weighted sums
    logic [3:0][24:0] w_s, r_f2_s;
    logic             r_f2_v, r_f2_load;
    logic [16:0]      r_f2_f;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            w_s[c] = 25'(w_rd0[8*c +: 8]) * 25'(17'h10000 - {1'b0, r_f1_x}) +
                     25'(w_rd1[8*c +: 8]) * 25'(r_f1_x);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f2_v <= 1'b0;
        end else if (en) begin
            r_f2_v <= r_f1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f2_load <= r_f1_load;
            r_f2_f    <= r_f1_f;
            r_f2_s    <= w_s;
        end
    end

    // F3: rounding and packing
    gpg_pkg::t_res    w_res, r_f3_res;
    logic             r_f3_v;
    logic [3:0][24:0] w_r8, w_r16;

    always_comb begin
        for (int c = 0; c < 4; c++) begin
            w_r8[c]  = r_f2_s[c] + 25'd32768;
            w_r16[c] = r_f2_s[c] + 25'd128;
        end
        if (i_cfg.deep_output) begin
            w_res.value = {w_r16[3][23:8], w_r16[2][23:8], w_r16[1][23:8], w_r16[0][23:8]};
        end else begin
            w_res.value = {32'b0, w_r8[3][23:16], w_r8[2][23:16],
                           w_r8[1][23:16], w_r8[0][23:16]};
        end
        w_res.factor = r_f2_f;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f3_v <= 1'b0;
        end else if (en) begin
            r_f3_v <= r_f2_v & ~r_f2_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_f3_res <= w_res;
        end
    end

    assign o_res_valid = en & r_f3_v;
    assign o_res       = r_f3_res;
endmodule

FILE: hdl/gradient_pixel_generator_top.sv
// Top level of the gradient pixel generator: configuration registers and wiring.
//
// Takes one item per clock while the output queue has space, and returns one
// result per pixel item, in order; palette loads give no result. The back-end
// pipeline holds the 32-step quotient divider followed by the 16-step square
// root (the 16-step CORDIC and the 46-step spiral divider run alongside).
// Loads travel the same pipeline and write the palette where pixels read
// it, so a load affects every later pixel. A pop stall holds the whole
// back end; the input queue absorbs two items. Palette entries must be
// loaded before pixels use them. The user must write configuration only
// while no items are in flight; the block itself does not enforce it.
module gradient_pixel_generator_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [18:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic        i_kind,
    input  logic [11:0] i_pixel_x,
    input  logic [11:0] i_pixel_y,
    input  logic [3:0]  i_entry_index,
    input  logic [31:0] i_entry_color,
    output logic        empty,
    input  logic        pop,
    output logic [63:0] o_pixel_value,
    output logic [16:0] o_blend_factor
);
    gpg_pkg::t_cfg  r_cfg;
    gpg_pkg::t_item w_item;
    gpg_pkg::t_res  w_res, w_head;
    logic           w_avail, w_take, w_space, w_res_valid;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.origin_x      <= 19'sd0;
            r_cfg.origin_y      <= 19'sd0;
            r_cfg.dest_x        <= 19'sd0;
            r_cfg.dest_y        <= 19'sd0;
            r_cfg.gradient_type <= gpg_pkg::GT_LINEAR;
            r_cfg.color_count   <= 5'd2;
            r_cfg.deep_output   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gpg_pkg::CFG_ORIGIN_X:      r_cfg.origin_x      <= i_cfg_data;
                gpg_pkg::CFG_ORIGIN_Y:      r_cfg.origin_y      <= i_cfg_data;
                gpg_pkg::CFG_DEST_X:        r_cfg.dest_x        <= i_cfg_data;
                gpg_pkg::CFG_DEST_Y:        r_cfg.dest_y        <= i_cfg_data;
                gpg_pkg::CFG_GRADIENT_TYPE: r_cfg.gradient_type <= i_cfg_data[2:0];
                gpg_pkg::CFG_COLOR_COUNT:   r_cfg.color_count   <= i_cfg_data[4:0];
                gpg_pkg::CFG_DEEP_OUTPUT:   r_cfg.deep_output   <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    gpg_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_kind        (i_kind),
        .i_pixel_x     (i_pixel_x),
        .i_pixel_y     (i_pixel_y),
        .i_entry_index (i_entry_index),
        .i_entry_color (i_entry_color),
        .i_take        (w_take),
        .o_avail       (w_avail),
        .o_item        (w_item)
    );

    gpg_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_avail     (w_avail),
        .i_item      (w_item),
        .o_take      (w_take),
        .i_space     (w_space),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    gpg_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_res   (w_res),
        .o_space (w_space),
        .empty   (empty),
        .pop     (pop),
        .o_res   (w_head)
    );

    assign o_pixel_value  = w_head.value;
    assign o_blend_factor = w_head.factor;
endmodule
